// ----- rtl/core/pitag_pkg.sv -----
`default_nettype none

package pitag_pkg;

  // Default tile buffer geometry.
  localparam int unsigned TILE_CHANNELS_DEF = 4;
  localparam int unsigned TILE_ROWS_DEF     = 16;
  localparam int unsigned TILE_COLS_DEF     = 16;

  // Configuration port widths.
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 13;

  // Register widths.
  localparam int unsigned CHANNELS_W = 13;
  localparam int unsigned MAP_DIM_W  = 11;
  localparam int unsigned STRIDE_W   = 4;
  localparam int unsigned PADDING_W  = 3;

  // Input field widths.
  localparam int unsigned CH_OFS_W  = 12;
  localparam int unsigned POS_OFS_W = 10;

  // Output field widths.
  localparam int unsigned SLOT_CH_W  = 2;
  localparam int unsigned SLOT_POS_W = 4;
  localparam int unsigned ADDR_W     = 32;

  // Signed map position: slot index (4 bits) plus a scaled offset (14 bits).
  localparam int unsigned POS_W = 18;

  // Configuration register indexes.
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_CHANNELS   = 3'd0,
    CFG_MAP_HEIGHT = 3'd1,
    CFG_MAP_WIDTH  = 3'd2,
    CFG_STRIDE     = 3'd3,
    CFG_PADDING    = 3'd4
  } pitag_cfg_e;

  // Request kinds.
  typedef enum logic {
    KIND_START = 1'b0,
    KIND_STEP  = 1'b1
  } pitag_kind_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load_tile;
    logic step;
    logic mul_a;
    logic mul_b;
    logic emit;
  } pitag_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic active;
  } pitag_status_t;

endpackage

`default_nettype wire

// ----- rtl/core/padded_input_tile_address_gen.sv -----
// Channel    Direction  Handshake                  Payload
// cfg        in         cfg_we_i                   cfg_idx_i, cfg_wdata_i
// in         in         in_valid_i / in_stall_o    kind, channel/row/col offsets
// out        out        out_valid_o / out_stall_i  slot indices, address, fetch, last
//
// A start request gives no result.
// A step request on an active tile goes through coordinate capture, two multiply
// stages for channel*H*W and row*W, then the final add into the output register.
// The next request is taken once the output register has been loaded, even if it is held.
// Reset is asynchronous, active low and reaches all but the pipeline and output registers.
`default_nettype none

module padded_input_tile_address_gen #(
  parameter int unsigned TILE_CHANNELS = pitag_pkg::TILE_CHANNELS_DEF,
  parameter int unsigned TILE_ROWS     = pitag_pkg::TILE_ROWS_DEF,
  parameter int unsigned TILE_COLS     = pitag_pkg::TILE_COLS_DEF
) (
  input  wire logic                               clk_i,
  input  wire logic                               rst_ni,
  input  wire logic                               cfg_we_i,
  input  wire logic [pitag_pkg::CFG_IDX_W-1:0]    cfg_idx_i,
  input  wire logic [pitag_pkg::CFG_DATA_W-1:0]   cfg_wdata_i,
  input  wire logic                               in_valid_i,
  output logic                                    in_stall_o,
  input  wire logic                               in_kind_i,
  input  wire logic [pitag_pkg::CH_OFS_W-1:0]     in_channel_offset_i,
  input  wire logic [pitag_pkg::POS_OFS_W-1:0]    in_row_offset_i,
  input  wire logic [pitag_pkg::POS_OFS_W-1:0]    in_col_offset_i,
  output logic                                    out_valid_o,
  input  wire logic                               out_stall_i,
  output logic [pitag_pkg::SLOT_CH_W-1:0]         out_slot_channel_o,
  output logic [pitag_pkg::SLOT_POS_W-1:0]        out_slot_row_o,
  output logic [pitag_pkg::SLOT_POS_W-1:0]        out_slot_col_o,
  output logic [pitag_pkg::ADDR_W-1:0]            out_word_address_o,
  output logic                                    out_fetch_o,
  output logic                                    out_last_o
);

  pitag_pkg::pitag_cmd_t    cmd;
  pitag_pkg::pitag_status_t status;

  // Sequencer.
  pitag_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_kind_i   (in_kind_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .cmd_o       (cmd),
    .status_i    (status)
  );

  // Counters, address arithmetic and output register.
  pitag_datapath #(
    .TILE_CHANNELS (TILE_CHANNELS),
    .TILE_ROWS     (TILE_ROWS),
    .TILE_COLS     (TILE_COLS)
  ) u_datapath (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .cfg_we_i            (cfg_we_i),
    .cfg_idx_i           (cfg_idx_i),
    .cfg_wdata_i         (cfg_wdata_i),
    .cmd_i               (cmd),
    .status_o            (status),
    .in_channel_offset_i (in_channel_offset_i),
    .in_row_offset_i     (in_row_offset_i),
    .in_col_offset_i     (in_col_offset_i),
    .out_slot_channel_o  (out_slot_channel_o),
    .out_slot_row_o      (out_slot_row_o),
    .out_slot_col_o      (out_slot_col_o),
    .out_word_address_o  (out_word_address_o),
    .out_fetch_o         (out_fetch_o),
    .out_last_o          (out_last_o)
  );

endmodule

`default_nettype wire

// ----- rtl/core/pitag_ctrl.sv -----
`default_nettype none

module pitag_ctrl (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  in_valid_i,
  output logic                       in_stall_o,
  input  wire logic                  in_kind_i,
  output logic                       out_valid_o,
  input  wire logic                  out_stall_i,
  output pitag_pkg::pitag_cmd_t      cmd_o,
  input  wire pitag_pkg::pitag_status_t status_i
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_PROD,
    S_SCALE,
    S_EMIT
  } state_e;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;
  logic   in_accept;
  logic   out_free;

  // Requests are taken only while no step is in flight.
  assign in_stall_o  = (state_q != S_IDLE);
  assign in_accept   = in_valid_i && !in_stall_o;
  assign out_valid_o = out_valid_q;
  assign out_free    = !out_valid_q || !out_stall_i;

  // Sequencing of one step through the multiply chain.
  always_comb begin
    state_d     = state_q;
    out_valid_d = out_valid_q && out_stall_i;
    cmd_o       = '0;
    case (state_q)
      S_IDLE: begin
        if (in_accept) begin
          if (in_kind_i == pitag_pkg::KIND_START) begin
            cmd_o.load_tile = 1'b1;
          end else if (status_i.active) begin
            cmd_o.step = 1'b1;
            state_d    = S_PROD;
          end
        end
      end
      S_PROD: begin
        cmd_o.mul_a = 1'b1;
        state_d     = S_SCALE;
      end
      S_SCALE: begin
        cmd_o.mul_b = 1'b1;
        state_d     = S_EMIT;
      end
      S_EMIT: begin
        if (out_free) begin
          cmd_o.emit  = 1'b1;
          out_valid_d = 1'b1;
          state_d     = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // State and output valid.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

`ifndef ASSERT_OFF
  // A finished result waits while the output register is still held.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_EMIT && out_valid_q && out_stall_i) |=> (state_q == S_EMIT))
    else $error("result left the emit state while the output was held");

  // A step on an active tile starts the multiply chain.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_accept && in_kind_i == pitag_pkg::KIND_STEP && status_i.active)
      |=> (state_q == S_PROD))
    else $error("accepted step did not enter the multiply chain");

  // A start request never produces a result.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_accept && in_kind_i == pitag_pkg::KIND_START) |=> (state_q == S_IDLE))
    else $error("start request left the idle state");

  // New results appear only from the emit state.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !$past(out_valid_q && out_stall_i)) |-> $past(state_q == S_EMIT))
    else $error("result raised outside the emit state");
`endif

endmodule

`default_nettype wire

// ----- rtl/core/pitag_datapath.sv -----
`default_nettype none

module pitag_datapath #(
  parameter int unsigned TILE_CHANNELS = pitag_pkg::TILE_CHANNELS_DEF,
  parameter int unsigned TILE_ROWS     = pitag_pkg::TILE_ROWS_DEF,
  parameter int unsigned TILE_COLS     = pitag_pkg::TILE_COLS_DEF
) (
  input  wire logic                               clk_i,
  input  wire logic                               rst_ni,
  input  wire logic                               cfg_we_i,
  input  wire logic [pitag_pkg::CFG_IDX_W-1:0]    cfg_idx_i,
  input  wire logic [pitag_pkg::CFG_DATA_W-1:0]   cfg_wdata_i,
  input  wire pitag_pkg::pitag_cmd_t              cmd_i,
  output pitag_pkg::pitag_status_t                status_o,
  input  wire logic [pitag_pkg::CH_OFS_W-1:0]     in_channel_offset_i,
  input  wire logic [pitag_pkg::POS_OFS_W-1:0]    in_row_offset_i,
  input  wire logic [pitag_pkg::POS_OFS_W-1:0]    in_col_offset_i,
  output logic [pitag_pkg::SLOT_CH_W-1:0]         out_slot_channel_o,
  output logic [pitag_pkg::SLOT_POS_W-1:0]        out_slot_row_o,
  output logic [pitag_pkg::SLOT_POS_W-1:0]        out_slot_col_o,
  output logic [pitag_pkg::ADDR_W-1:0]            out_word_address_o,
  output logic                                    out_fetch_o,
  output logic                                    out_last_o
);

  localparam int unsigned CH_W  = (TILE_CHANNELS > 1) ? $clog2(TILE_CHANNELS) : 1;
  localparam int unsigned ROW_W = (TILE_ROWS > 1) ? $clog2(TILE_ROWS) : 1;
  localparam int unsigned COL_W = (TILE_COLS > 1) ? $clog2(TILE_COLS) : 1;

  localparam int unsigned POS_W   = pitag_pkg::POS_W;
  localparam int unsigned SCL_W   = pitag_pkg::POS_OFS_W + pitag_pkg::STRIDE_W;
  localparam int unsigned CHS_W   = pitag_pkg::CHANNELS_W;
  localparam int unsigned DIM_W   = pitag_pkg::MAP_DIM_W;
  localparam int unsigned PCH_W   = CHS_W + DIM_W;
  localparam int unsigned PROW_W  = 2 * DIM_W;
  localparam int unsigned PCHW_W  = PCH_W + DIM_W;
  localparam int unsigned ADDR_W  = pitag_pkg::ADDR_W;

  // Configuration registers.
  logic [CHS_W-1:0]                  channels_q;
  logic [DIM_W-1:0]                  height_q;
  logic [DIM_W-1:0]                  width_q;
  logic [pitag_pkg::STRIDE_W-1:0]    stride_q;
  logic [pitag_pkg::PADDING_W-1:0]   padding_q;

  // Tile state.
  logic                              active_q;
  logic [pitag_pkg::CH_OFS_W-1:0]    base_ch_q;
  logic [pitag_pkg::POS_OFS_W-1:0]   base_row_q;
  logic [pitag_pkg::POS_OFS_W-1:0]   base_col_q;
  logic [CH_W-1:0]                   ch_cnt_q;
  logic [ROW_W-1:0]                  row_cnt_q;
  logic [COL_W-1:0]                  col_cnt_q;

  // Slot coordinates for the current step.
  logic [SCL_W-1:0]                  row_scaled;
  logic [SCL_W-1:0]                  col_scaled;
  logic [POS_W-1:0]                  row_pos;
  logic [POS_W-1:0]                  col_pos;
  logic [CHS_W-1:0]                  chan_sum;
  logic                              row_ok;
  logic                              col_ok;
  logic                              chan_ok;
  logic                              col_wrap;
  logic                              row_wrap;
  logic                              last_slot;

  // Pipeline registers.
  logic [CHS_W-1:0]                  s1_chan_q;
  logic [DIM_W-1:0]                  s1_row_q;
  logic [DIM_W-1:0]                  s1_col_q;
  logic                              s1_fetch_q;
  logic                              s1_last_q;
  logic [pitag_pkg::SLOT_CH_W-1:0]   s1_slot_ch_q;
  logic [pitag_pkg::SLOT_POS_W-1:0]  s1_slot_row_q;
  logic [pitag_pkg::SLOT_POS_W-1:0]  s1_slot_col_q;
  logic [PCH_W-1:0]                  prod_ch_q;
  logic [PROW_W-1:0]                 prod_row_q;
  logic [PCHW_W-1:0]                 prod_chw;
  logic [ADDR_W-1:0]                 chw_q;
  logic [ADDR_W-1:0]                 rc_q;

  // Output register.
  logic [pitag_pkg::SLOT_CH_W-1:0]   out_slot_ch_q;
  logic [pitag_pkg::SLOT_POS_W-1:0]  out_slot_row_q;
  logic [pitag_pkg::SLOT_POS_W-1:0]  out_slot_col_q;
  logic [ADDR_W-1:0]                 out_addr_q;
  logic                              out_fetch_q;
  logic                              out_last_q;

  assign status_o.active = active_q;

  // Configuration writes; unknown indexes are ignored.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      channels_q <= CHS_W'(1);
      height_q   <= DIM_W'(1);
      width_q    <= DIM_W'(1);
      stride_q   <= pitag_pkg::STRIDE_W'(1);
      padding_q  <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        pitag_pkg::CFG_CHANNELS:   channels_q <= cfg_wdata_i[CHS_W-1:0];
        pitag_pkg::CFG_MAP_HEIGHT: height_q   <= cfg_wdata_i[DIM_W-1:0];
        pitag_pkg::CFG_MAP_WIDTH:  width_q    <= cfg_wdata_i[DIM_W-1:0];
        pitag_pkg::CFG_STRIDE:     stride_q   <= cfg_wdata_i[pitag_pkg::STRIDE_W-1:0];
        pitag_pkg::CFG_PADDING:    padding_q  <= cfg_wdata_i[pitag_pkg::PADDING_W-1:0];
        default: ;
      endcase
    end
  end

  // Map position of the current slot: index plus scaled offset minus padding.
  assign row_scaled = SCL_W'(base_row_q) * SCL_W'(stride_q);
  assign col_scaled = SCL_W'(base_col_q) * SCL_W'(stride_q);
  assign row_pos    = POS_W'(row_cnt_q) + POS_W'(row_scaled) - POS_W'(padding_q);
  assign col_pos    = POS_W'(col_cnt_q) + POS_W'(col_scaled) - POS_W'(padding_q);
  assign chan_sum   = CHS_W'(base_ch_q) + CHS_W'(ch_cnt_q);

  assign row_ok  = !row_pos[POS_W-1] && (row_pos[POS_W-2:0] < (POS_W-1)'(height_q));
  assign col_ok  = !col_pos[POS_W-1] && (col_pos[POS_W-2:0] < (POS_W-1)'(width_q));
  assign chan_ok = chan_sum < channels_q;

  assign col_wrap  = (col_cnt_q == COL_W'(TILE_COLS - 1));
  assign row_wrap  = (row_cnt_q == ROW_W'(TILE_ROWS - 1));
  assign last_slot = col_wrap && row_wrap && (ch_cnt_q == CH_W'(TILE_CHANNELS - 1));

  // Tile state: loaded on start, walked column-first on each step.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q   <= 1'b0;
      base_ch_q  <= '0;
      base_row_q <= '0;
      base_col_q <= '0;
      ch_cnt_q   <= '0;
      row_cnt_q  <= '0;
      col_cnt_q  <= '0;
    end else if (cmd_i.load_tile) begin
      active_q   <= 1'b1;
      base_ch_q  <= in_channel_offset_i;
      base_row_q <= in_row_offset_i;
      base_col_q <= in_col_offset_i;
      ch_cnt_q   <= '0;
      row_cnt_q  <= '0;
      col_cnt_q  <= '0;
    end else if (cmd_i.step) begin
      if (last_slot) begin
        active_q  <= 1'b0;
        ch_cnt_q  <= '0;
        row_cnt_q <= '0;
        col_cnt_q <= '0;
      end else if (!col_wrap) begin
        col_cnt_q <= col_cnt_q + COL_W'(1);
      end else begin
        col_cnt_q <= '0;
        if (!row_wrap) begin
          row_cnt_q <= row_cnt_q + ROW_W'(1);
        end else begin
          row_cnt_q <= '0;
          ch_cnt_q  <= ch_cnt_q + CH_W'(1);
        end
      end
    end
  end

  // Capture the slot coordinates; row and column are only used when in range.
  always_ff @(posedge clk_i) begin
    if (cmd_i.step) begin
      s1_chan_q     <= chan_sum;
      s1_row_q      <= row_pos[DIM_W-1:0];
      s1_col_q      <= col_pos[DIM_W-1:0];
      s1_fetch_q    <= chan_ok && row_ok && col_ok;
      s1_last_q     <= last_slot;
      s1_slot_ch_q  <= pitag_pkg::SLOT_CH_W'(ch_cnt_q);
      s1_slot_row_q <= pitag_pkg::SLOT_POS_W'(row_cnt_q);
      s1_slot_col_q <= pitag_pkg::SLOT_POS_W'(col_cnt_q);
    end
  end

  // First products: channel times height, row times width.
  always_ff @(posedge clk_i) begin
    if (cmd_i.mul_a) begin
      prod_ch_q  <= PCH_W'(s1_chan_q) * PCH_W'(height_q);
      prod_row_q <= PROW_W'(s1_row_q) * PROW_W'(width_q);
    end
  end

  // Second product: channel offset (channel times plane size); row term plus column.
  assign prod_chw = PCHW_W'(prod_ch_q) * PCHW_W'(width_q);

  always_ff @(posedge clk_i) begin
    if (cmd_i.mul_b) begin
      chw_q <= prod_chw[ADDR_W-1:0];
      rc_q  <= ADDR_W'(prod_row_q) + ADDR_W'(s1_col_q);
    end
  end

  // Output register, loaded when the previous result has been taken.
  always_ff @(posedge clk_i) begin
    if (cmd_i.emit) begin
      out_slot_ch_q  <= s1_slot_ch_q;
      out_slot_row_q <= s1_slot_row_q;
      out_slot_col_q <= s1_slot_col_q;
      out_addr_q     <= s1_fetch_q ? (chw_q + rc_q) : '0;
      out_fetch_q    <= s1_fetch_q;
      out_last_q     <= s1_last_q;
    end
  end

  assign out_slot_channel_o = out_slot_ch_q;
  assign out_slot_row_o     = out_slot_row_q;
  assign out_slot_col_o     = out_slot_col_q;
  assign out_word_address_o = out_addr_q;
  assign out_fetch_o        = out_fetch_q;
  assign out_last_o         = out_last_q;

endmodule

`default_nettype wire

// ----- bench/tb_padded_input_tile_address_gen.sv -----
`timescale 1ns / 100ps

module tb_padded_input_tile_address_gen;
  import pitag_pkg::*;

  localparam int unsigned SETTLE_CYCLES  = 8;
  localparam int unsigned WATCHDOG_LIMIT = 4000;
  localparam int unsigned RANDOM_ITEMS   = 1875;
  localparam int unsigned PHASE_ITEMS    = 120;
  localparam int unsigned PRINT_LIMIT    = 30;
  localparam int unsigned TILE_SLOTS     = TILE_CHANNELS_DEF * TILE_ROWS_DEF * TILE_COLS_DEF;

  // One slot of the tile fill sequence, as the block reports it.
  typedef struct packed {
    logic [SLOT_CH_W-1:0]  slot_channel;
    logic [SLOT_POS_W-1:0] slot_row;
    logic [SLOT_POS_W-1:0] slot_col;
    logic [ADDR_W-1:0]     word_address;
    logic                  fetch;
    logic                  last;
  } slot_rec_t;

  typedef enum bit {ROW_CFG, ROW_REQ} row_op_e;
  typedef enum int unsigned {STALL_NONE, STALL_SOME, STALL_HEAVY} stall_mode_e;

  // One line of the directed plan: a register write or a request.
  typedef struct {
    row_op_e                op;
    pitag_cfg_e             sel;
    logic [CFG_DATA_W-1:0]  wdata;
    pitag_kind_e            kind;
    logic [CH_OFS_W-1:0]    ch_ofs;
    logic [POS_OFS_W-1:0]   row_ofs;
    logic [POS_OFS_W-1:0]   col_ofs;
    bit                     typed;
    slot_rec_t              want;
  } plan_row_t;

  logic                  clk_i = 1'b0;
  logic                  rst_ni = 1'b0;
  logic                  cfg_we_i = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_idx_i = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata_i = '0;
  logic                  in_valid_i = 1'b0;
  logic                  in_stall_o;
  logic                  in_kind_i = 1'b0;
  logic [CH_OFS_W-1:0]   in_channel_offset_i = '0;
  logic [POS_OFS_W-1:0]  in_row_offset_i = '0;
  logic [POS_OFS_W-1:0]  in_col_offset_i = '0;
  logic                  out_valid_o;
  logic                  out_stall_i = 1'b0;
  logic [SLOT_CH_W-1:0]  out_slot_channel_o;
  logic [SLOT_POS_W-1:0] out_slot_row_o;
  logic [SLOT_POS_W-1:0] out_slot_col_o;
  logic [ADDR_W-1:0]     out_word_address_o;
  logic                  out_fetch_o;
  logic                  out_last_o;

  // Mirror of the configuration registers, at their reset values.
  logic [CHANNELS_W-1:0] cap_channels = CHANNELS_W'(1);
  logic [MAP_DIM_W-1:0]  map_h = MAP_DIM_W'(1);
  logic [MAP_DIM_W-1:0]  map_w = MAP_DIM_W'(1);
  logic [STRIDE_W-1:0]   stride_r = STRIDE_W'(1);
  logic [PADDING_W-1:0]  pad_r = '0;

  // Mirror of the tile walker state.
  bit                    tile_active = 1'b0;
  logic [CH_OFS_W-1:0]   base_ch = '0;
  logic [POS_OFS_W-1:0]  base_row = '0;
  logic [POS_OFS_W-1:0]  base_col = '0;
  int unsigned           cnt_ch = 0;
  int unsigned           cnt_row = 0;
  int unsigned           cnt_col = 0;

  slot_rec_t   pending_slots[$];
  plan_row_t   plan_rows[$];
  bit          typed_pending = 1'b0;
  slot_rec_t   typed_slot = '0;
  int unsigned error_count = 0;
  int unsigned idle_cycles = 0;
  int unsigned counted_items = 0;
  int unsigned burst_left = 0;
  stall_mode_e stall_mode = STALL_NONE;
  int unsigned stall_left = 0;

  padded_input_tile_address_gen dut (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .cfg_we_i            (cfg_we_i),
    .cfg_idx_i           (cfg_idx_i),
    .cfg_wdata_i         (cfg_wdata_i),
    .in_valid_i          (in_valid_i),
    .in_stall_o          (in_stall_o),
    .in_kind_i           (in_kind_i),
    .in_channel_offset_i (in_channel_offset_i),
    .in_row_offset_i     (in_row_offset_i),
    .in_col_offset_i     (in_col_offset_i),
    .out_valid_o         (out_valid_o),
    .out_stall_i         (out_stall_i),
    .out_slot_channel_o  (out_slot_channel_o),
    .out_slot_row_o      (out_slot_row_o),
    .out_slot_col_o      (out_slot_col_o),
    .out_word_address_o  (out_word_address_o),
    .out_fetch_o         (out_fetch_o),
    .out_last_o          (out_last_o)
  );

  // 10 ns clock.
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // The receiver switches between no stall, light stall and heavy stall.
  always @(negedge clk_i) begin
    if (stall_left == 0) begin
      stall_mode = stall_mode_e'($urandom_range(0, 2));
      stall_left = $urandom_range(20, 200);
    end
    stall_left--;
    case (stall_mode)
      STALL_NONE: out_stall_i <= 1'b0;
      STALL_SOME: out_stall_i <= ($urandom_range(0, 1) == 1);
      default:    out_stall_i <= ($urandom_range(0, 7) != 0);
    endcase
  end

  task automatic report_error(input string msg);
    error_count++;
    if (error_count <= PRINT_LIMIT) begin
      $display("ERROR at %0t ns: %s", $time, msg);
    end
  endtask

  task automatic check_field(input string name, input logic [ADDR_W-1:0] got,
                             input logic [ADDR_W-1:0] want);
    if (got !== want) begin
      report_error($sformatf("%s got %0h want %0h", name, got, want));
    end
  endtask

  // Works out the slot that a request yields, and advances the walker mirror.
  // Returns 1 when the request yields a slot.
  function automatic bit next_fill_slot(input pitag_kind_e kind,
                                        input logic [CH_OFS_W-1:0] ch_ofs,
                                        input logic [POS_OFS_W-1:0] row_ofs,
                                        input logic [POS_OFS_W-1:0] col_ofs,
                                        output slot_rec_t slot);
    longint chan;
    longint row;
    longint col;
    longint addr;
    slot = '0;
    // A start opens a new tile, dropping any tile still in progress.
    if (kind == KIND_START) begin
      base_ch = ch_ofs;
      base_row = row_ofs;
      base_col = col_ofs;
      cnt_ch = 0;
      cnt_row = 0;
      cnt_col = 0;
      tile_active = 1'b1;
      return 1'b0;
    end
    if (!tile_active) begin
      return 1'b0;
    end

    chan = longint'(base_ch) + longint'(cnt_ch);
    row = longint'(cnt_row) + longint'(base_row) * longint'(stride_r) - longint'(pad_r);
    col = longint'(cnt_col) + longint'(base_col) * longint'(stride_r) - longint'(pad_r);
    slot.slot_channel = cnt_ch[SLOT_CH_W-1:0];
    slot.slot_row = cnt_row[SLOT_POS_W-1:0];
    slot.slot_col = cnt_col[SLOT_POS_W-1:0];
    slot.fetch = chan < longint'(cap_channels) && row >= 0 && row < longint'(map_h)
              && col >= 0 && col < longint'(map_w);
    if (slot.fetch) begin
      addr = chan * longint'(map_h) * longint'(map_w) + row * longint'(map_w) + col;
      slot.word_address = addr[ADDR_W-1:0];
    end
    slot.last = cnt_ch == TILE_CHANNELS_DEF - 1 && cnt_row == TILE_ROWS_DEF - 1
             && cnt_col == TILE_COLS_DEF - 1;

    // Column innermost, then row, then channel; the last slot closes the tile.
    if (slot.last) begin
      tile_active = 1'b0;
      cnt_ch = 0;
      cnt_row = 0;
      cnt_col = 0;
    end else if (cnt_col + 1 < TILE_COLS_DEF) begin
      cnt_col++;
    end else begin
      cnt_col = 0;
      if (cnt_row + 1 < TILE_ROWS_DEF) begin
        cnt_row++;
      end else begin
        cnt_row = 0;
        cnt_ch++;
      end
    end
    return 1'b1;
  endfunction

  // Sample both channels and the register port at each rising edge.
  always @(posedge clk_i) begin : monitor
    slot_rec_t want;
    slot_rec_t predicted;
    bit        busy;
    if (rst_ni) begin
      busy = 1'b0;

      if (cfg_we_i) begin
        busy = 1'b1;
        case (cfg_idx_i)
          CFG_CHANNELS:   cap_channels = cfg_wdata_i[CHANNELS_W-1:0];
          CFG_MAP_HEIGHT: map_h = cfg_wdata_i[MAP_DIM_W-1:0];
          CFG_MAP_WIDTH:  map_w = cfg_wdata_i[MAP_DIM_W-1:0];
          CFG_STRIDE:     stride_r = cfg_wdata_i[STRIDE_W-1:0];
          CFG_PADDING:    pad_r = cfg_wdata_i[PADDING_W-1:0];
          default: ;
        endcase
      end

      // Compare each result with the oldest slot still owed.
      if (out_valid_o && !out_stall_i) begin
        busy = 1'b1;
        if (pending_slots.size() == 0) begin
          report_error($sformatf("result with no request owed: ch %0d row %0d col %0d",
                                 out_slot_channel_o, out_slot_row_o, out_slot_col_o));
        end else begin
          want = pending_slots.pop_front();
          check_field("slot_channel", ADDR_W'(out_slot_channel_o),
                      ADDR_W'(want.slot_channel));
          check_field("slot_row", ADDR_W'(out_slot_row_o), ADDR_W'(want.slot_row));
          check_field("slot_col", ADDR_W'(out_slot_col_o), ADDR_W'(want.slot_col));
          check_field("word_address", out_word_address_o, want.word_address);
          check_field("fetch", ADDR_W'(out_fetch_o), ADDR_W'(want.fetch));
          check_field("last", ADDR_W'(out_last_o), ADDR_W'(want.last));
        end
      end

      if (in_valid_i && !in_stall_o) begin
        busy = 1'b1;
        if (next_fill_slot(pitag_kind_e'(in_kind_i), in_channel_offset_i, in_row_offset_i,
                           in_col_offset_i, predicted)) begin
          pending_slots.push_back(typed_pending ? typed_slot : predicted);
        end
      end

      // Watchdog on cycles with no traffic at all.
      idle_cycles = busy ? 0 : idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("padded_input_tile_address_gen regression: fail");
        $finish;
      end
    end
  end

  task automatic write_reg(input pitag_cfg_e sel, input logic [CFG_DATA_W-1:0] value);
    @(negedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= sel;
    cfg_wdata_i <= value;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  // Present one request, with a random gap between bursts, and wait until it is taken.
  task automatic send_request(input pitag_kind_e kind, input logic [CH_OFS_W-1:0] ch_ofs,
                              input logic [POS_OFS_W-1:0] row_ofs,
                              input logic [POS_OFS_W-1:0] col_ofs,
                              input bit typed = 1'b0, input slot_rec_t want = '0);
    int unsigned gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      burst_left = $urandom_range(1, 40);
      if (gap > 0) begin
        @(negedge clk_i);
        in_valid_i <= 1'b0;
        repeat (gap - 1) @(negedge clk_i);
      end
    end
    burst_left--;
    @(negedge clk_i);
    if (kind == KIND_START || tile_active) begin
      counted_items++;
    end
    typed_pending = typed;
    typed_slot = want;
    in_valid_i <= 1'b1;
    in_kind_i <= kind;
    in_channel_offset_i <= ch_ofs;
    in_row_offset_i <= row_ofs;
    in_col_offset_i <= col_ofs;
    do @(posedge clk_i); while (in_stall_o);
  endtask

  // Hold off the sender until every owed slot has come back, then let the pipe settle.
  task automatic drain_outputs();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (pending_slots.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  // Offsets that land tiles near the map, with an occasional wild value.
  function automatic logic [POS_OFS_W-1:0] pick_pos_offset(input logic [MAP_DIM_W-1:0] dim);
    int unsigned hi;
    if (stride_r == 0 || $urandom_range(0, 3) == 0) begin
      return POS_OFS_W'($urandom_range(0, 1023));
    end
    hi = (32'(dim) + 32'(pad_r)) / 32'(stride_r);
    if (hi > 1023) hi = 1023;
    return POS_OFS_W'($urandom_range(0, hi));
  endfunction

  function automatic logic [CH_OFS_W-1:0] pick_channel_offset();
    int unsigned hi;
    if (cap_channels == 0 || $urandom_range(0, 3) == 0) begin
      return CH_OFS_W'($urandom_range(0, 4095));
    end
    hi = 32'(cap_channels) - 1;
    if (hi > 4095) hi = 4095;
    return CH_OFS_W'($urandom_range(0, hi));
  endfunction

  function automatic plan_row_t req_row(input pitag_kind_e kind,
                                        input logic [CH_OFS_W-1:0] ch_ofs,
                                        input logic [POS_OFS_W-1:0] row_ofs,
                                        input logic [POS_OFS_W-1:0] col_ofs);
    plan_row_t r;
    r = '{op: ROW_REQ, sel: CFG_CHANNELS, wdata: '0, kind: kind, ch_ofs: ch_ofs,
          row_ofs: row_ofs, col_ofs: col_ofs, typed: 1'b0, want: '0};
    return r;
  endfunction

  function automatic plan_row_t typed_step(input slot_rec_t want);
    plan_row_t r;
    r = req_row(KIND_STEP, '0, '0, '0);
    r.typed = 1'b1;
    r.want = want;
    return r;
  endfunction

  function automatic plan_row_t cfg_row(input pitag_cfg_e sel,
                                        input logic [CFG_DATA_W-1:0] value);
    plan_row_t r;
    r = req_row(KIND_START, '0, '0, '0);
    r.op = ROW_CFG;
    r.sel = sel;
    r.wdata = value;
    return r;
  endfunction

  initial begin : stimulus
    slot_rec_t   zero_slot;
    logic [CHANNELS_W-1:0] v_ch;
    logic [MAP_DIM_W-1:0]  v_h;
    logic [MAP_DIM_W-1:0]  v_w;
    logic [STRIDE_W-1:0]   v_s;
    logic [PADDING_W-1:0]  v_p;
    int unsigned phase;
    int unsigned phase_base;
    int unsigned choice;

    zero_slot = '0;

    // Directed plan, starting from the reset settings of a 1x1x1 map.
    // A step with no open tile is ignored.
    plan_rows.push_back(req_row(KIND_STEP, 12'hFFF, 10'h3FF, 10'h3FF));
    plan_rows.push_back(req_row(KIND_START, '0, '0, '0));
    plan_rows.push_back(typed_step('{2'd0, 4'd0, 4'd0, 32'd0, 1'b1, 1'b0}));
    plan_rows.push_back(typed_step('{2'd0, 4'd0, 4'd1, 32'd0, 1'b0, 1'b0}));
    // Channel beyond the map: zero fill.
    plan_rows.push_back(req_row(KIND_START, 12'hFFF, 10'h3FF, 10'h3FF));
    plan_rows.push_back(typed_step(zero_slot));
    // Largest legal map: the top corner gives the highest address.
    plan_rows.push_back(cfg_row(CFG_CHANNELS, 13'd4096));
    plan_rows.push_back(cfg_row(CFG_MAP_HEIGHT, 13'd1024));
    plan_rows.push_back(cfg_row(CFG_MAP_WIDTH, 13'd1024));
    plan_rows.push_back(cfg_row(CFG_STRIDE, 13'd1));
    plan_rows.push_back(cfg_row(CFG_PADDING, 13'd0));
    plan_rows.push_back(req_row(KIND_START, 12'hFFF, 10'h3FF, 10'h3FF));
    plan_rows.push_back(typed_step('{2'd0, 4'd0, 4'd0, 32'hFFFF_FFFF, 1'b1, 1'b0}));
    plan_rows.push_back(typed_step('{2'd0, 4'd0, 4'd1, 32'd0, 1'b0, 1'b0}));
    // Stride of 8 and largest padding; the first slot falls in the top padding.
    plan_rows.push_back(cfg_row(CFG_STRIDE, 13'd8));
    plan_rows.push_back(cfg_row(CFG_PADDING, 13'd7));
    plan_rows.push_back(req_row(KIND_START, '0, '0, '0));
    plan_rows.push_back(typed_step(zero_slot));
    // A new start abandons the open tile.
    plan_rows.push_back(req_row(KIND_START, '0, 10'd1, 10'd1));
    plan_rows.push_back(req_row(KIND_STEP, '0, '0, '0));
    plan_rows.push_back(req_row(KIND_STEP, '0, '0, '0));
    // Zero stride: the offsets drop out.
    plan_rows.push_back(cfg_row(CFG_STRIDE, 13'd0));
    plan_rows.push_back(cfg_row(CFG_PADDING, 13'd0));
    plan_rows.push_back(req_row(KIND_START, 12'd3, 10'h3FF, 10'h3FF));
    plan_rows.push_back(req_row(KIND_STEP, '0, '0, '0));
    // Zero channels, then zero height, then zero width: nothing is fetched.
    plan_rows.push_back(cfg_row(CFG_CHANNELS, 13'd0));
    plan_rows.push_back(req_row(KIND_START, '0, '0, '0));
    plan_rows.push_back(typed_step(zero_slot));
    plan_rows.push_back(cfg_row(CFG_CHANNELS, 13'd4));
    plan_rows.push_back(cfg_row(CFG_MAP_HEIGHT, 13'd0));
    plan_rows.push_back(req_row(KIND_START, '0, '0, '0));
    plan_rows.push_back(typed_step(zero_slot));
    plan_rows.push_back(cfg_row(CFG_MAP_HEIGHT, 13'd5));
    plan_rows.push_back(cfg_row(CFG_MAP_WIDTH, 13'd0));
    plan_rows.push_back(req_row(KIND_START, '0, '0, '0));
    plan_rows.push_back(typed_step(zero_slot));
    // All-ones register values: the address wraps past 32 bits.
    plan_rows.push_back(cfg_row(CFG_CHANNELS, 13'h1FFF));
    plan_rows.push_back(cfg_row(CFG_MAP_HEIGHT, 13'h7FF));
    plan_rows.push_back(cfg_row(CFG_MAP_WIDTH, 13'h7FF));
    plan_rows.push_back(cfg_row(CFG_STRIDE, 13'hF));
    plan_rows.push_back(cfg_row(CFG_PADDING, 13'h7));
    plan_rows.push_back(req_row(KIND_START, 12'hFFF, 10'd100, 10'd100));
    plan_rows.push_back(req_row(KIND_STEP, '0, '0, '0));
    plan_rows.push_back(req_row(KIND_STEP, '0, '0, '0));

    repeat (12) @(negedge clk_i);
    rst_ni <= 1'b1;

    // Walk the directed plan; registers change only once the block is idle.
    foreach (plan_rows[i]) begin
      if (plan_rows[i].op == ROW_CFG) begin
        if (i == 0 || plan_rows[i - 1].op != ROW_CFG) drain_outputs();
        write_reg(plan_rows[i].sel, plan_rows[i].wdata);
      end else begin
        send_request(plan_rows[i].kind, plan_rows[i].ch_ofs, plan_rows[i].row_ofs,
                     plan_rows[i].col_ofs, plan_rows[i].typed, plan_rows[i].want);
      end
    end

    // Random phases, each under its own settings.
    counted_items = 0;
    phase = 0;
    while (counted_items < RANDOM_ITEMS) begin
      drain_outputs();
      case (phase)
        0: begin
          v_ch = CHANNELS_W'($urandom_range(1, 6));
          v_h = MAP_DIM_W'($urandom_range(1, 24));
          v_w = MAP_DIM_W'($urandom_range(1, 24));
          v_s = STRIDE_W'($urandom_range(1, 3));
          v_p = PADDING_W'($urandom_range(0, 7));
        end
        1: begin
          v_ch = CHANNELS_W'(1);
          v_h = MAP_DIM_W'(1);
          v_w = MAP_DIM_W'(1);
          v_s = STRIDE_W'(1);
          v_p = '0;
        end
        2: begin
          v_ch = CHANNELS_W'(4096);
          v_h = MAP_DIM_W'(1024);
          v_w = MAP_DIM_W'(1024);
          v_s = STRIDE_W'(8);
          v_p = PADDING_W'(7);
        end
        default: begin
          v_ch = CHANNELS_W'($urandom_range(0, 1) ? $urandom_range(1, 8)
                                                  : $urandom_range(1, 4096));
          v_h = MAP_DIM_W'($urandom_range(0, 1) ? $urandom_range(1, 32)
                                                : $urandom_range(1, 1024));
          v_w = MAP_DIM_W'($urandom_range(0, 1) ? $urandom_range(1, 32)
                                                : $urandom_range(1, 1024));
          v_s = STRIDE_W'($urandom_range(1, 8));
          v_p = PADDING_W'($urandom_range(0, 7));
        end
      endcase
      write_reg(CFG_CHANNELS, CFG_DATA_W'(v_ch));
      write_reg(CFG_MAP_HEIGHT, CFG_DATA_W'(v_h));
      write_reg(CFG_MAP_WIDTH, CFG_DATA_W'(v_w));
      write_reg(CFG_STRIDE, CFG_DATA_W'(v_s));
      write_reg(CFG_PADDING, CFG_DATA_W'(v_p));

      if (phase == 0) begin
        // One complete tile, then a step that finds the walker idle again.
        send_request(KIND_START, pick_channel_offset(), pick_pos_offset(map_h),
                     pick_pos_offset(map_w));
        repeat (TILE_SLOTS + 1) begin
          send_request(KIND_STEP, CH_OFS_W'($urandom_range(0, 4095)),
                       POS_OFS_W'($urandom_range(0, 1023)),
                       POS_OFS_W'($urandom_range(0, 1023)));
        end
      end else begin
        phase_base = counted_items;
        while (counted_items - phase_base < PHASE_ITEMS && counted_items < RANDOM_ITEMS) begin
          choice = $urandom_range(0, 9);
          if (choice < 8) begin
            // A tile fragment placed near the map.
            send_request(KIND_START, pick_channel_offset(), pick_pos_offset(map_h),
                         pick_pos_offset(map_w));
            repeat ($urandom_range(1, 40)) begin
              send_request(KIND_STEP, CH_OFS_W'($urandom_range(0, 4095)),
                           POS_OFS_W'($urandom_range(0, 1023)),
                           POS_OFS_W'($urandom_range(0, 1023)));
            end
          end else if (choice == 8) begin
            // A wild start, cut short by whatever comes next.
            send_request(KIND_START, CH_OFS_W'($urandom_range(0, 4095)),
                         POS_OFS_W'($urandom_range(0, 1023)),
                         POS_OFS_W'($urandom_range(0, 1023)));
            repeat ($urandom_range(0, 2)) begin
              send_request(KIND_STEP, CH_OFS_W'($urandom_range(0, 4095)),
                           POS_OFS_W'($urandom_range(0, 1023)),
                           POS_OFS_W'($urandom_range(0, 1023)));
            end
          end else begin
            send_request(KIND_STEP, CH_OFS_W'($urandom_range(0, 4095)),
                         POS_OFS_W'($urandom_range(0, 1023)),
                         POS_OFS_W'($urandom_range(0, 1023)));
          end
          // Now and then let the output side run dry before going on.
          if ($urandom_range(0, 59) == 0) drain_outputs();
        end
      end
      phase++;
    end

    drain_outputs();
    if (error_count == 0) begin
      $display("padded_input_tile_address_gen regression: pass");
    end else begin
      $display("padded_input_tile_address_gen regression: fail");
    end
    $finish;
  end

endmodule
